// File: design/mic_pkg.sv
// Package for the multilevel interrupt controller: request types, codes and helpers.
package mic_pkg;

    // Function codes carried in the func field of an input request.
    localparam logic [2:0] FUNC_POST   = 3'd0;
    localparam logic [2:0] FUNC_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_READ   = 3'd2;
    localparam logic [2:0] FUNC_ACCEPT = 3'd3;
    localparam logic [2:0] FUNC_RETURN = 3'd4;

    // Register addresses.
    localparam logic [1:0] REG_STATUS = 2'd0;
    localparam logic [1:0] REG_RR_PTR = 2'd1;
    localparam logic [1:0] REG_CTRL   = 2'd2;

    // Request levels.
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_MED  = 2'd2;
    localparam logic [1:0] LVL_HIGH = 2'd3;

    // Bit positions in the status and control registers.
    localparam int BIT_LOW  = 0;
    localparam int BIT_MED  = 1;
    localparam int BIT_HIGH = 2;
    localparam int BIT_RR   = 7;

    // Width of one leaf group of the priority search tree.
    localparam int GROUP_W = 16;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Search classes: high, medium, low, and low above the round-robin pointer.
    localparam int CLS_HIGH     = 0;
    localparam int CLS_MED      = 1;
    localparam int CLS_LOW      = 2;
    localparam int CLS_LOW_NEXT = 3;
    localparam int NUM_CLS      = 4;

    typedef struct packed {
        logic [2:0] func;
        logic [6:0] vector;
        logic [1:0] level;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
    } mic_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       accepted;
        logic [6:0] vector_taken;
        logic [7:0] jump_address;
    } mic_out_t;

    typedef enum logic [2:0] {
        OP_POST,
        OP_WRITE,
        OP_READ,
        OP_ACCEPT,
        OP_RETURN,
        OP_NONE
    } mic_op_t;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        mic_op_t    op;
        logic [6:0] vector;
        logic [1:0] level;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
    } mic_cmd_t;

    typedef enum logic [1:0] {
        S_EXEC,
        S_REDUCE,
        S_GROUP,
        S_SELECT
    } mic_state_t;

    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } mic_pe_t;

    // Lowest set bit of a 16-bit word, built as two 8-bit encoders and a merge.
    function automatic mic_pe_t mic_pe16(input logic [15:0] v);
        mic_pe_t    r;
        logic [2:0] il;
        logic [2:0] ih;
        il = 3'd0;
        ih = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                il = 3'(i);
            end
            if (v[i + 8]) begin
                ih = 3'(i);
            end
        end
        r.found = |v;
        r.idx   = (|v[7:0]) ? {1'b0, il} : {1'b1, ih};
        return r;
    endfunction

endpackage

// File: design/multilevel_interrupt_controller.sv
// Top level of the multilevel interrupt controller.
//
//   Channel  Ports                       Direction  Carries
//   input    s_valid, s_ready, s_data    in         mic_in_t request (func and operands)
//   result   m_valid, m_ready, m_data    out        mic_out_t result, one per request
//
// Each request passes through the back end in order: execute, round-robin pointer
// reduction, leaf encoding of the vector groups and root selection.
// A two-entry queue takes requests while the back end is busy; the output
// register holds a finished result while the next request is being worked on.
// A stalled result holds the back end in its selection step until it is taken.
// Reset clears control state but not data registers; there is no clearing pass.
module multilevel_interrupt_controller #(
    parameter int NUM_VECTORS = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mic_pkg::mic_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mic_pkg::mic_out_t m_data
);
    import mic_pkg::*;

    logic     q_full;
    logic     q_push;
    mic_cmd_t q_push_cmd;
    logic     q_pop;
    logic     q_head_valid;
    mic_cmd_t q_head_cmd;

    // Classification of incoming requests.
    mic_front #(
        .NUM_VECTORS(NUM_VECTORS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_push_cmd)
    );

    // Queue between the two halves.
    mic_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // State update, priority search and result register.
    mic_back #(
        .NUM_VECTORS(NUM_VECTORS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_head_valid),
        .q_cmd   (q_head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: design/mic_front.sv
// Front end: checks incoming requests and classifies them into queue commands.
module mic_front #(
    parameter int NUM_VECTORS = 128
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  mic_pkg::mic_in_t  s_data,
    input  logic              q_full,
    output logic              q_push,
    output mic_pkg::mic_cmd_t q_cmd
);
    import mic_pkg::*;

    // The front end takes a request whenever the queue has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Decode the function code; a post to a vector beyond the count does nothing.
    always_comb begin
        q_cmd.vector     = s_data.vector;
        q_cmd.level      = s_data.level;
        q_cmd.reg_addr   = s_data.reg_addr;
        q_cmd.write_data = s_data.write_data;
        unique case (s_data.func)
            FUNC_POST: begin
                q_cmd.op = (int'(s_data.vector) < NUM_VECTORS) ? OP_POST : OP_NONE;
            end
            FUNC_WRITE:  q_cmd.op = OP_WRITE;
            FUNC_READ:   q_cmd.op = OP_READ;
            FUNC_ACCEPT: q_cmd.op = OP_ACCEPT;
            FUNC_RETURN: q_cmd.op = OP_RETURN;
            default:     q_cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: design/mic_queue.sv
// Short command queue that decouples the front end from the back end.
module mic_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mic_pkg::mic_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output mic_pkg::mic_cmd_t head_cmd
);
    import mic_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mic_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/mic_back.sv
// Back end: applies commands to the controller state and runs the priority search.
module mic_back #(
    parameter int NUM_VECTORS = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  mic_pkg::mic_cmd_t q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mic_pkg::mic_out_t m_data
);
    import mic_pkg::*;

    localparam int IDX_W = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
    localparam int NG    = (NUM_VECTORS + GROUP_W - 1) / GROUP_W;
    localparam int RECIP = 65536 / NUM_VECTORS;

    mic_state_t       state_reg;
    mic_state_t       state_next;

    logic [1:0]       levels_reg [NUM_VECTORS];
    logic [1:0]       levels_next [NUM_VECTORS];
    logic [7:0]       status_reg;
    logic [7:0]       status_next;
    logic [7:0]       ptr_reg;
    logic [7:0]       ptr_next;
    logic [7:0]       ctrl_reg;
    logic [7:0]       ctrl_next;

    logic             chosen_valid_reg;
    logic             chosen_valid_next;
    logic [IDX_W-1:0] chosen_vec_reg;
    logic [IDX_W-1:0] chosen_vec_next;
    logic [1:0]       chosen_lvl_reg;
    logic [1:0]       chosen_lvl_next;

    logic [7:0]       res_rd_reg;
    logic [7:0]       res_rd_next;
    logic             res_acc_reg;
    logic             res_acc_next;
    logic [6:0]       res_vec_reg;
    logic [6:0]       res_vec_next;
    logic [7:0]       res_jump_reg;
    logic [7:0]       res_jump_next;

    logic [7:0]       quot_reg;
    logic [7:0]       quot_next;
    logic [IDX_W-1:0] rr_base_reg;
    logic [IDX_W-1:0] rr_base_next;

    logic [NG-1:0]    grp_found_reg [NUM_CLS];
    logic [NG-1:0]    grp_found_next [NUM_CLS];
    logic [3:0]       grp_idx_reg [NUM_CLS][NG];
    logic [3:0]       grp_idx_next [NUM_CLS][NG];

    logic             out_valid_reg;
    logic             out_valid_next;
    mic_out_t         out_data_reg;
    mic_out_t         out_data_next;

    logic             exec_fire;
    logic             out_free;
    logic [24:0]      quot_prod;
    logic [16:0]      quot_times_n;
    logic [8:0]       rem_raw;
    logic [8:0]       rem_fix;
    logic [7:0]       chosen_wide;
    logic [NG*GROUP_W-1:0] cls_vec [NUM_CLS];
    logic             sel_found [NUM_CLS];
    logic [7:0]       sel_vec [NUM_CLS];
    mic_pe_t          top_pe;
    mic_pe_t          leaf_pe;
    logic [3:0]       leaf_idx;
    logic [7:0]       mask;

    assign exec_fire   = (state_reg == S_EXEC) && q_valid;
    assign q_pop       = exec_fire;
    assign out_free    = !out_valid_reg || m_ready;
    assign m_valid     = out_valid_reg;
    assign m_data      = out_data_reg;
    assign chosen_wide = 8'(chosen_vec_reg);

    // Sequencer: execute, reduce the round-robin pointer, encode groups, select.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_EXEC:   if (q_valid) state_next = S_REDUCE;
            S_REDUCE: state_next = S_GROUP;
            S_GROUP:  state_next = S_SELECT;
            S_SELECT: if (out_free) state_next = S_EXEC;
            default:  state_next = S_EXEC;
        endcase
    end

    // Effect of one command on the registers and on the result fields.
    always_comb begin
        levels_next   = levels_reg;
        status_next   = status_reg;
        ptr_next      = ptr_reg;
        ctrl_next     = ctrl_reg;
        res_rd_next   = res_rd_reg;
        res_acc_next  = res_acc_reg;
        res_vec_next  = res_vec_reg;
        res_jump_next = res_jump_reg;
        if (exec_fire) begin
            res_rd_next   = 8'd0;
            res_acc_next  = 1'b0;
            res_vec_next  = 7'd0;
            res_jump_next = 8'd0;
            unique case (q_cmd.op)
                OP_POST: begin
                    for (int k = 0; k < NUM_VECTORS; k++) begin
                        if (int'(q_cmd.vector) == k) begin
                            levels_next[k] = q_cmd.level;
                        end
                    end
                end
                OP_WRITE: begin
                    unique case (q_cmd.reg_addr)
                        REG_STATUS: status_next = q_cmd.write_data;
                        REG_RR_PTR: ptr_next    = q_cmd.write_data;
                        REG_CTRL:   ctrl_next   = q_cmd.write_data;
                        default:    ;
                    endcase
                end
                OP_READ: begin
                    unique case (q_cmd.reg_addr)
                        REG_STATUS: res_rd_next = status_reg;
                        REG_RR_PTR: res_rd_next = ptr_reg;
                        REG_CTRL:   res_rd_next = ctrl_reg;
                        default:    res_rd_next = 8'd0;
                    endcase
                end
                OP_ACCEPT: begin
                    if (chosen_valid_reg) begin
                        unique case (chosen_lvl_reg)
                            LVL_HIGH: status_next[BIT_HIGH] = 1'b1;
                            LVL_MED:  status_next[BIT_MED]  = 1'b1;
                            LVL_LOW: begin
                                status_next[BIT_LOW] = 1'b1;
                                if (ctrl_reg[BIT_RR]) begin
                                    ptr_next = chosen_wide;
                                end
                            end
                            default: ;
                        endcase
                        res_acc_next  = 1'b1;
                        res_vec_next  = chosen_wide[6:0];
                        res_jump_next = {chosen_wide[6:0], 1'b0};
                    end
                end
                OP_RETURN: begin
                    if (status_reg[BIT_HIGH]) begin
                        status_next[BIT_HIGH] = 1'b0;
                    end else if (status_reg[BIT_MED]) begin
                        status_next[BIT_MED] = 1'b0;
                    end else if (status_reg[BIT_LOW]) begin
                        status_next[BIT_LOW] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Pointer modulo the vector count: reciprocal estimate, then one correction.
    always_comb begin
        quot_prod    = 25'(ptr_next) * 25'(RECIP);
        quot_next    = exec_fire ? quot_prod[23:16] : quot_reg;
        quot_times_n = 17'(quot_reg) * 17'(NUM_VECTORS);
        rem_raw      = 9'(ptr_reg) - quot_times_n[8:0];
        rem_fix      = (rem_raw >= 9'(NUM_VECTORS)) ? rem_raw - 9'(NUM_VECTORS) : rem_raw;
        rr_base_next = (state_reg == S_REDUCE) ? rem_fix[IDX_W-1:0] : rr_base_reg;
    end

    // Leaf stage of the search tree: lowest candidate in each group of vectors.
    always_comb begin
        for (int c = 0; c < NUM_CLS; c++) begin
            cls_vec[c] = '0;
        end
        for (int k = 0; k < NUM_VECTORS; k++) begin
            cls_vec[CLS_HIGH][k]     = (levels_reg[k] == LVL_HIGH);
            cls_vec[CLS_MED][k]      = (levels_reg[k] == LVL_MED);
            cls_vec[CLS_LOW][k]      = (levels_reg[k] == LVL_LOW);
            cls_vec[CLS_LOW_NEXT][k] = (levels_reg[k] == LVL_LOW) && (k > int'(rr_base_reg));
        end
        for (int c = 0; c < NUM_CLS; c++) begin
            for (int g = 0; g < NG; g++) begin
                leaf_pe              = mic_pe16(cls_vec[c][g*GROUP_W +: GROUP_W]);
                grp_found_next[c][g] = (state_reg == S_GROUP) ? leaf_pe.found
                                                              : grp_found_reg[c][g];
                grp_idx_next[c][g]   = (state_reg == S_GROUP) ? leaf_pe.idx
                                                              : grp_idx_reg[c][g];
            end
        end
    end

    // Root stage: first group with a candidate, then its leaf index.
    always_comb begin
        for (int c = 0; c < NUM_CLS; c++) begin
            top_pe   = mic_pe16(16'(grp_found_reg[c]));
            leaf_idx = 4'd0;
            for (int g = 0; g < NG; g++) begin
                if (4'(g) == top_pe.idx) begin
                    leaf_idx = grp_idx_reg[c][g];
                end
            end
            sel_found[c] = top_pe.found;
            sel_vec[c]   = {top_pe.idx, leaf_idx};
        end
    end

    // Final choice by level, honouring enables, executing levels and round-robin.
    always_comb begin
        mask              = ctrl_reg & ~status_reg;
        chosen_valid_next = chosen_valid_reg;
        chosen_vec_next   = chosen_vec_reg;
        chosen_lvl_next   = chosen_lvl_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_data_next     = out_data_reg;
        if (state_reg == S_SELECT && out_free) begin
            chosen_valid_next = 1'b1;
            if (mask[BIT_HIGH] && sel_found[CLS_HIGH]) begin
                chosen_vec_next = sel_vec[CLS_HIGH][IDX_W-1:0];
                chosen_lvl_next = LVL_HIGH;
            end else if (mask[BIT_MED] && sel_found[CLS_MED]) begin
                chosen_vec_next = sel_vec[CLS_MED][IDX_W-1:0];
                chosen_lvl_next = LVL_MED;
            end else if (mask[BIT_LOW] && ctrl_reg[BIT_RR] && sel_found[CLS_LOW_NEXT]) begin
                chosen_vec_next = sel_vec[CLS_LOW_NEXT][IDX_W-1:0];
                chosen_lvl_next = LVL_LOW;
            end else if (mask[BIT_LOW] && sel_found[CLS_LOW]) begin
                chosen_vec_next = sel_vec[CLS_LOW][IDX_W-1:0];
                chosen_lvl_next = LVL_LOW;
            end else begin
                chosen_valid_next = 1'b0;
                chosen_vec_next   = '0;
                chosen_lvl_next   = LVL_NONE;
            end
            out_valid_next             = 1'b1;
            out_data_next.read_data    = res_rd_reg;
            out_data_next.irq_request  = chosen_valid_next;
            out_data_next.accepted     = res_acc_reg;
            out_data_next.vector_taken = res_vec_reg;
            out_data_next.jump_address = res_jump_reg;
        end
    end

    // Control state and controller registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_EXEC;
            status_reg       <= 8'd0;
            ptr_reg          <= 8'd0;
            ctrl_reg         <= 8'd0;
            chosen_valid_reg <= 1'b0;
            chosen_vec_reg   <= '0;
            chosen_lvl_reg   <= LVL_NONE;
            out_valid_reg    <= 1'b0;
            for (int k = 0; k < NUM_VECTORS; k++) begin
                levels_reg[k] <= LVL_NONE;
            end
        end else begin
            state_reg        <= state_next;
            status_reg       <= status_next;
            ptr_reg          <= ptr_next;
            ctrl_reg         <= ctrl_next;
            chosen_valid_reg <= chosen_valid_next;
            chosen_vec_reg   <= chosen_vec_next;
            chosen_lvl_reg   <= chosen_lvl_next;
            out_valid_reg    <= out_valid_next;
            levels_reg       <= levels_next;
        end
    end

    // Working registers of the search and result payload.
    always_ff @(posedge aclk) begin
        res_rd_reg    <= res_rd_next;
        res_acc_reg   <= res_acc_next;
        res_vec_reg   <= res_vec_next;
        res_jump_reg  <= res_jump_next;
        quot_reg      <= quot_next;
        rr_base_reg   <= rr_base_next;
        grp_found_reg <= grp_found_next;
        grp_idx_reg   <= grp_idx_next;
        out_data_reg  <= out_data_next;
    end

endmodule
